FILE: hdl/kris_pkg.sv
// kris_pkg: shared types and constants for the interval scheduler
// no dependencies

package kris_pkg;

   // top level control states, one-hot
   typedef enum logic [3:0] {
      ST_LOAD   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   localparam int COUNT_BITS = 9;
   localparam int PERSONS_BITS = 5;

endpackage

FILE: hdl/kris_sort_cell.sv
// kris_sort_cell: one cell of the insertion sorter chain
// depends on nothing but its neighbors in the chain

module kris_sort_cell #(
   parameter int TIME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 ins_valid,
   input  logic [TIME_BITS-1:0] ins_start,
   input  logic [TIME_BITS-1:0] ins_end,
   input  logic                 shift_out,
   input  logic                 prev_valid,
   input  logic                 prev_moves,
   input  logic [TIME_BITS-1:0] prev_start,
   input  logic [TIME_BITS-1:0] prev_end,
   output logic                 moves,
   output logic                 cell_valid,
   output logic [TIME_BITS-1:0] cell_start,
   output logic [TIME_BITS-1:0] cell_end
);

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] start_ff, start_in, end_ff, end_in;

   // cell yields its place when it is empty or holds a later end
   assign moves      = !valid_ff || (end_ff > ins_end);
   assign cell_valid = valid_ff;
   assign cell_start = start_ff;
   assign cell_end   = end_ff;

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      end_in   = end_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (shift_out) begin
         // scan: take the neighbor's entry
         valid_in = prev_valid;
         start_in = prev_start;
         end_in   = prev_end;
      end else if (ins_valid && moves) begin
         if (prev_moves) begin
            valid_in = prev_valid;
            start_in = prev_start;
            end_in   = prev_end;
         end else begin
            valid_in = 1'b1;
            start_in = ins_start;
            end_in   = ins_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
   end

endmodule

FILE: hdl/kris_resource_cell.sv
// kris_resource_cell: one resource, holds its busy-until time
// depends on kris_pkg

module kris_resource_cell
   import kris_pkg::*;
#(
   parameter int TIME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 enabled,
   input  logic                 grant,
   input  logic [TIME_BITS-1:0] job_start,
   input  logic [TIME_BITS-1:0] job_end,
   output logic                 fits,
   output logic [TIME_BITS:0]   key
);

   logic                 used_ff;
   logic [TIME_BITS-1:0] busy_ff;

   // key is busy time plus one, zero when free
   assign fits = enabled && (!used_ff || busy_ff <= job_start);
   assign key  = used_ff ? ({1'b0, busy_ff} + 1'b1) : '0;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         used_ff <= 1'b0;
      end else if (grant) begin
         used_ff <= 1'b1;
      end
      if (grant) begin
         busy_ff <= job_end;
      end
   end

endmodule

FILE: hdl/k_resource_interval_scheduler_top.sv
// k_resource_interval_scheduler_top: collects intervals, sorts, greedy k-resource pick
// depends on kris_pkg, kris_sort_cell, kris_resource_cell
//
//  channel | ports                                          | direction
//  req     | start, busy, req_start_time, req_end_time, req_last_item | in (busy out)
//  rsp     | rsp_valid, rsp_selected_count, rsp_overflow    | out
//  csr     | csr_write, csr_data (persons)                  | in
//
// Loading: the sorter chain inserts each accepted item in place, and the next
// item may follow at once while busy is low. After the last item the chain shifts
// out one interval per cycle to the resource cells; the result strobe is raised in
// ST_REPORT after ST_WAIT and ST_SCAN, and busy stays high through these states.
// Reset is synchronous and clears the chain and resources; the scan never stalls.

module k_resource_interval_scheduler_top
   import kris_pkg::*;
#(
   parameter int MAX_INTERVALS = 256,
   parameter int MAX_RESOURCES = 16,
   parameter int TIME_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [15:0]           req_start_time,
   input  logic [15:0]           req_end_time,
   input  logic                  req_last_item,
   output logic                  rsp_valid,
   output logic [COUNT_BITS-1:0] rsp_selected_count,
   output logic                  rsp_overflow,
   input  logic                  csr_write,
   input  logic [PERSONS_BITS-1:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int RIX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int RES_P2 = 1 << RIX_W;

   state_type state_ff, state_in;
   logic [PERSONS_BITS-1:0] persons_ff;
   logic [CNT_W-1:0] count_ff, count_in, left_ff, left_in;
   logic [COUNT_BITS-1:0] sel_ff, sel_in;
   logic ovf_ff, ovf_in;

   logic accept, ins, scan, clear_all;
   logic [TIME_BITS-1:0] s_t, e_t;

   logic [MAX_INTERVALS:0]  c_valid, c_moves;
   logic [TIME_BITS-1:0]    c_start [MAX_INTERVALS+1];
   logic [TIME_BITS-1:0]    c_end   [MAX_INTERVALS+1];

   assign accept = start && !busy;
   assign s_t = TIME_BITS'(req_start_time);
   assign e_t = TIME_BITS'(req_end_time);
   assign ins = accept && (count_ff < CNT_W'(MAX_INTERVALS));
   assign scan = (state_ff == ST_SCAN);
   assign clear_all = (state_ff == ST_REPORT);
   assign busy = (state_ff != ST_LOAD);

   // chain head: the incoming interval; cell 1 reads it
   assign c_valid[0] = 1'b0;
   assign c_moves[0] = 1'b0;
   assign c_start[0] = s_t;
   assign c_end[0]   = e_t;

   // sorter chain, ordered by end time, cell 1 holds the earliest
   for (genvar i = 1; i <= MAX_INTERVALS; i++) begin : g_sort
      logic [TIME_BITS-1:0] ps, pe;
      logic pv;
      // on scan, cells shift toward the head: take from i+1
      if (i < MAX_INTERVALS) begin : g_mid
         assign pv = scan ? c_valid[i+1] : c_valid[i-1];
         assign ps = scan ? c_start[i+1] : c_start[i-1];
         assign pe = scan ? c_end[i+1]   : c_end[i-1];
      end else begin : g_last
         assign pv = scan ? 1'b0 : c_valid[i-1];
         assign ps = c_start[i-1];
         assign pe = c_end[i-1];
      end
      kris_sort_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock(clock), .reset(reset), .clear(clear_all),
         .ins_valid(ins), .ins_start(s_t), .ins_end(e_t),
         .shift_out(scan), .prev_valid(pv), .prev_moves(c_moves[i-1]),
         .prev_start(ps), .prev_end(pe),
         .moves(c_moves[i]), .cell_valid(c_valid[i]),
         .cell_start(c_start[i]), .cell_end(c_end[i])
      );
   end

   // resource cells judge the head interval in parallel
   logic [MAX_RESOURCES-1:0] fits, grant;
   logic [TIME_BITS:0] keys [MAX_RESOURCES];
   logic [PERSONS_BITS-1:0] n_sat;
   logic found;
   logic [RIX_W-1:0] best;
   logic do_pick;
   logic               t_ok  [2*RES_P2];
   logic [TIME_BITS:0] t_key [2*RES_P2];
   logic [RIX_W-1:0]   t_ix  [2*RES_P2];

   assign n_sat = (32'(persons_ff) > MAX_RESOURCES) ? PERSONS_BITS'(MAX_RESOURCES)
                                                    : persons_ff;
   assign do_pick = scan && (left_ff != '0);

   for (genvar r = 0; r < MAX_RESOURCES; r++) begin : g_res
      kris_resource_cell #(.TIME_BITS(TIME_BITS)) u_res (
         .clock(clock), .reset(reset), .clear(clear_all),
         .enabled(32'(r) < 32'(n_sat)), .grant(grant[r]),
         .job_start(c_start[1]), .job_end(c_end[1]),
         .fits(fits[r]), .key(keys[r])
      );
   end

   // best fit by a compare tree: latest key, lower index on ties
   always_comb begin
      logic take_hi;
      take_hi = 1'b0;
      for (int n = 0; n < 2 * RES_P2; n++) begin
         t_ok[n]  = 1'b0;
         t_key[n] = '0;
         t_ix[n]  = '0;
      end
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         t_ok[RES_P2 + r]  = fits[r];
         t_key[RES_P2 + r] = keys[r];
         t_ix[RES_P2 + r]  = RIX_W'(r);
      end
      for (int n = RES_P2 - 1; n >= 1; n--) begin
         take_hi = t_ok[2*n+1] && (!t_ok[2*n] || (t_key[2*n+1] > t_key[2*n]));
         if (take_hi) begin
            t_ok[n]  = 1'b1;
            t_key[n] = t_key[2*n+1];
            t_ix[n]  = t_ix[2*n+1];
         end else begin
            t_ok[n]  = t_ok[2*n];
            t_key[n] = t_key[2*n];
            t_ix[n]  = t_ix[2*n];
         end
      end
      found = t_ok[1];
      best  = t_ix[1];
      grant = '0;
      if (do_pick && found) begin
         grant[best] = 1'b1;
      end
   end

   // control sequence
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      left_in  = left_ff;
      sel_in   = sel_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (ins) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_item) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            left_in  = count_ff;
            sel_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (left_ff == '0) begin
               state_in = ST_REPORT;
            end else begin
               left_in = left_ff - 1'b1;
               if (found) begin
                  sel_in = sel_ff + 1'b1;
               end
            end
         end
         ST_REPORT: begin
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_valid          = clear_all;
   assign rsp_selected_count = sel_ff;
   assign rsp_overflow       = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         persons_ff <= 5'd1;
         count_ff   <= '0;
         left_ff    <= '0;
         sel_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         sel_ff   <= sel_in;
         ovf_ff   <= ovf_in;
         if (csr_write) begin
            persons_ff <= csr_data;
         end
      end
   end

endmodule
